### hdl/homogeneous_vector_alu_unit_assert.svh
// assertion macros for the homogeneous vector alu unit
`ifndef HOMOGENEOUS_VECTOR_ALU_UNIT_ASSERT_SVH
`define HOMOGENEOUS_VECTOR_ALU_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define HVA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hva check failed");

// next-cycle implication, sampled on clk, off during reset
`define HVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hva check failed");

`endif

### hdl/hva_pkg.sv
// shared types, codes and helpers for the homogeneous vector alu
`default_nettype none
package hva_pkg;

  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_SUB   = 3'd1;
  localparam logic [2:0] KIND_SCALE = 3'd2;
  localparam logic [2:0] KIND_DIVW  = 3'd3;
  localparam logic [2:0] KIND_NORM  = 3'd4;
  localparam logic [2:0] KIND_HOMOG = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_W    = 2'd1;
  localparam logic [1:0] ST_ZERO_LEN = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 32;
  localparam int LATENCY    = 4 + 2 * DIV_STEPS + SQRT_STEPS;

  // one lane of a restoring divider: remainder, numerator/quotient, divisor
  typedef struct packed {
    logic [31:0] rem;
    logic [47:0] nq;
    logic [31:0] d;
  } div_t;

  // digit-by-digit square root state
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] s;
  } sq_t;

  // item context that travels beside the cells
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               sat;
    logic [1:0]         st;
  } vec_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[31:0];
    if (v > S32_MAX) begin
      r.ovf = 1'b1;
      r.val = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      r.ovf = 1'b1;
      r.val = S32_MIN[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : v;
    return r;
  endfunction

  // signed value from a quotient magnitude, then clamp
  function automatic sat_t signed_quot(input logic [47:0] q, input logic neg);
    logic signed [63:0] qv;
    qv = {16'h0000, q};
    return sat64(neg ? -qv : qv);
  endfunction

endpackage
`default_nettype wire

### hdl/hva_div_cell.sv
// one restoring division step, registered
`default_nettype none
module hva_div_cell (
  input  wire logic          clk,
  input  wire hva_pkg::div_t din,
  output hva_pkg::div_t      dout
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    trial = {din.rem, din.nq[47]};
    diff  = trial - {1'b0, din.d};
    ge    = trial >= {1'b0, din.d};
  end

  always_ff @(posedge clk) begin
    dout.rem <= ge ? diff[31:0] : trial[31:0];
    dout.nq  <= {din.nq[46:0], ge};
    dout.d   <= din.d;
  end

endmodule
`default_nettype wire

### hdl/hva_sqrt_cell.sv
// one bit of integer square root, registered
`default_nettype none
module hva_sqrt_cell (
  input  wire logic         clk,
  input  wire hva_pkg::sq_t din,
  output hva_pkg::sq_t      dout
);

  logic [35:0] trial;
  logic [35:0] cand;
  logic [35:0] diff;
  logic        ge;

  always_comb begin
    trial = {din.rem, din.s[63:62]};
    cand  = {2'b00, din.root, 2'b01};
    diff  = trial - cand;
    ge    = trial >= cand;
  end

  always_ff @(posedge clk) begin
    dout.rem  <= ge ? diff[33:0] : trial[33:0];
    dout.root <= {din.root[30:0], ge};
    dout.s    <= {din.s[61:0], 2'b00};
  end

endmodule
`default_nettype wire

### hdl/homogeneous_vector_alu_unit.sv
// top level of the homogeneous vector alu: fixed-latency pipeline of cells
`default_nettype none
// one vector transfer is taken every clock cycle (start high, busy low; busy is
// high only during reset). each result is on res_* and status with done high
// for one cycle, and results leave in the order of their input transfers.
// the depth is set by two chains of 48 restoring-division cells (divide by w,
// then by the length), a chain of 32 square-root cells and four more
// registers (input, divider output, squares, output); every kind takes the
// same path, so results never reorder. the receiver cannot stall: a result is
// on res_* and status for exactly the cycle in which done is high and must be
// taken then.
module homogeneous_vector_alu_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         kind,
  input  wire logic signed [31:0] u_x,
  input  wire logic signed [31:0] u_y,
  input  wire logic signed [31:0] u_z,
  input  wire logic signed [31:0] u_w,
  input  wire logic signed [31:0] v_x,
  input  wire logic signed [31:0] v_y,
  input  wire logic signed [31:0] v_z,
  input  wire logic signed [31:0] v_w,
  input  wire logic signed [31:0] scale_factor,
  input  wire logic               point_flag,
  output logic                    done,
  output logic signed [31:0]      res_x,
  output logic signed [31:0]      res_y,
  output logic signed [31:0]      res_z,
  output logic signed [31:0]      res_w,
  output logic [1:0]              status
);

  localparam int ND = hva_pkg::DIV_STEPS;
  localparam int NS = hva_pkg::SQRT_STEPS;

  logic accept;

  // input stage: raw operands, products and sums
  logic                v1;
  logic [2:0]          k1;
  logic                pt1;
  logic signed [31:0]  u1 [4];
  logic signed [63:0]  p1 [3];
  logic signed [32:0]  s1 [4];
  logic signed [31:0]  uin [4];
  logic signed [31:0]  vin [4];

  // context shift lines beside the cell chains
  logic                va [ND];
  hva_pkg::vec_t       ca [ND];
  logic                vb;
  hva_pkg::vec_t       cb;
  logic                vc;
  hva_pkg::vec_t       cc;
  logic [63:0]         sq [3];
  logic                vd [NS];
  hva_pkg::vec_t       cd [NS];
  logic                ve [ND];
  hva_pkg::vec_t       ce [ND];

  hva_pkg::vec_t       c2_next;
  hva_pkg::vec_t       cb_next;
  hva_pkg::vec_t       fin_next;

  // cell chains: three lanes of each divider, one square root
  hva_pkg::div_t       d1w [3][ND+1];
  hva_pkg::div_t       d2w [3][ND+1];
  hva_pkg::sq_t        sqw [NS+1];

  logic signed [31:0]  cbx [3];
  logic signed [31:0]  cdx [3];

  // busy only while in reset; otherwise a transfer every cycle
  assign busy   = rst;
  assign accept = start & ~busy;

  assign uin[0] = u_x;
  assign uin[1] = u_y;
  assign uin[2] = u_z;
  assign uin[3] = u_w;
  assign vin[0] = v_x;
  assign vin[1] = v_y;
  assign vin[2] = v_z;
  assign vin[3] = v_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    k1  <= kind;
    pt1 <= point_flag;
    for (int i = 0; i < 4; i++) begin
      u1[i] <= uin[i];
      if (kind == hva_pkg::KIND_SUB) begin
        s1[i] <= 33'(uin[i]) - 33'(vin[i]);
      end else begin
        s1[i] <= 33'(uin[i]) + 33'(vin[i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      p1[i] <= 64'(scale_factor) * 64'(uin[i]);
    end
  end

  // results of the one-shot kinds; divide kinds carry u onward
  always_comb begin
    hva_pkg::sat_t r [4];
    logic          anysat;
    for (int i = 0; i < 4; i++) begin
      r[i] = '0;
    end
    anysat = 1'b0;
    c2_next = '0;
    c2_next.kind = k1;
    case (k1)
      hva_pkg::KIND_ADD, hva_pkg::KIND_SUB: begin
        for (int i = 0; i < 4; i++) begin
          r[i] = hva_pkg::sat64(64'(s1[i]));
          anysat = anysat | r[i].ovf;
        end
        c2_next.x = r[0].val;
        c2_next.y = r[1].val;
        c2_next.z = r[2].val;
        c2_next.w = r[3].val;
        c2_next.sat = anysat;
        if (r[3].val != 32'sd0 && r[3].val != hva_pkg::Q_ONE) begin
          c2_next.st = hva_pkg::ST_BAD_W;
        end
      end
      hva_pkg::KIND_SCALE: begin
        // arithmetic shift floors toward minus infinity
        for (int i = 0; i < 3; i++) begin
          r[i] = hva_pkg::sat64(p1[i] >>> 16);
          anysat = anysat | r[i].ovf;
        end
        c2_next.x = r[0].val;
        c2_next.y = r[1].val;
        c2_next.z = r[2].val;
        c2_next.w = u1[3];
        c2_next.sat = anysat;
      end
      hva_pkg::KIND_DIVW, hva_pkg::KIND_NORM: begin
        c2_next.x = u1[0];
        c2_next.y = u1[1];
        c2_next.z = u1[2];
        c2_next.w = u1[3];
      end
      hva_pkg::KIND_HOMOG: begin
        c2_next.x = u1[0];
        c2_next.y = u1[1];
        c2_next.z = u1[2];
        c2_next.w = pt1 ? hva_pkg::Q_ONE : 32'sd0;
      end
      default: begin
        c2_next.kind = k1;
      end
    endcase
  end

  // context line aligned with the first divider chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ND; k++) begin
        va[k] <= 1'b0;
      end
    end else begin
      va[0] <= v1;
      for (int k = 1; k < ND; k++) begin
        va[k] <= va[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    ca[0] <= c2_next;
    for (int k = 1; k < ND; k++) begin
      ca[k] <= ca[k-1];
    end
  end

  // first divider: |u_i| * 2^16 / |u_w|
  genvar l, k;
  generate
    for (l = 0; l < 3; l++) begin : g_div1
      assign d1w[l][0].rem = '0;
      assign d1w[l][0].nq  = {hva_pkg::mag32(u1[l]), 16'h0000};
      assign d1w[l][0].d   = hva_pkg::mag32(u1[3]);
      for (k = 0; k < ND; k++) begin : g_cell
        hva_div_cell u_cell (
          .clk  (clk),
          .din  (d1w[l][k]),
          .dout (d1w[l][k+1])
        );
      end
    end
  endgenerate

  // apply the divide by w: quotient truncates toward zero
  always_comb begin
    hva_pkg::sat_t q [3];
    logic          anysat;
    cb_next = ca[ND-1];
    anysat  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q[i] = hva_pkg::signed_quot(d1w[i][ND].nq, 1'b0);
    end
    if ((ca[ND-1].kind == hva_pkg::KIND_DIVW || ca[ND-1].kind == hva_pkg::KIND_NORM)
        && ca[ND-1].w != 32'sd0) begin
      q[0] = hva_pkg::signed_quot(d1w[0][ND].nq, ca[ND-1].x[31] ^ ca[ND-1].w[31]);
      q[1] = hva_pkg::signed_quot(d1w[1][ND].nq, ca[ND-1].y[31] ^ ca[ND-1].w[31]);
      q[2] = hva_pkg::signed_quot(d1w[2][ND].nq, ca[ND-1].z[31] ^ ca[ND-1].w[31]);
      for (int i = 0; i < 3; i++) begin
        anysat = anysat | q[i].ovf;
      end
      cb_next.x   = q[0].val;
      cb_next.y   = q[1].val;
      cb_next.z   = q[2].val;
      cb_next.w   = hva_pkg::Q_ONE;
      cb_next.sat = anysat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      vb <= va[ND-1];
      vc <= vb;
    end
  end

  assign cbx[0] = cb.x;
  assign cbx[1] = cb.y;
  assign cbx[2] = cb.z;

  // squares of the w-divided components
  always_ff @(posedge clk) begin
    cb <= cb_next;
    cc <= cb;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= 64'(64'(cbx[i]) * 64'(cbx[i]));
    end
  end

  // square root chain on the wrapped 64-bit sum of squares
  assign sqw[0].rem  = '0;
  assign sqw[0].root = '0;
  assign sqw[0].s    = sq[0] + sq[1] + sq[2];

  generate
    for (k = 0; k < NS; k++) begin : g_sqrt
      hva_sqrt_cell u_cell (
        .clk  (clk),
        .din  (sqw[k]),
        .dout (sqw[k+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NS; j++) begin
        vd[j] <= 1'b0;
      end
      for (int j = 0; j < ND; j++) begin
        ve[j] <= 1'b0;
      end
    end else begin
      vd[0] <= vc;
      for (int j = 1; j < NS; j++) begin
        vd[j] <= vd[j-1];
      end
      ve[0] <= vd[NS-1];
      for (int j = 1; j < ND; j++) begin
        ve[j] <= ve[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    cd[0] <= cc;
    for (int j = 1; j < NS; j++) begin
      cd[j] <= cd[j-1];
    end
    ce[0] <= cd[NS-1];
    for (int j = 1; j < ND; j++) begin
      ce[j] <= ce[j-1];
    end
  end

  assign cdx[0] = cd[NS-1].x;
  assign cdx[1] = cd[NS-1].y;
  assign cdx[2] = cd[NS-1].z;

  // second divider: |r_i| * 2^16 / length, length rides along as divisor
  generate
    for (l = 0; l < 3; l++) begin : g_div2
      assign d2w[l][0].rem = '0;
      assign d2w[l][0].nq  = {hva_pkg::mag32(cdx[l]), 16'h0000};
      assign d2w[l][0].d   = sqw[NS].root;
      for (k = 0; k < ND; k++) begin : g_cell
        hva_div_cell u_cell (
          .clk  (clk),
          .din  (d2w[l][k]),
          .dout (d2w[l][k+1])
        );
      end
    end
  endgenerate

  // normalize finish: zero length clears x, y, z
  always_comb begin
    hva_pkg::sat_t q [3];
    logic          anysat;
    fin_next = ce[ND-1];
    anysat   = ce[ND-1].sat;
    q[0] = hva_pkg::signed_quot(d2w[0][ND].nq, ce[ND-1].x[31]);
    q[1] = hva_pkg::signed_quot(d2w[1][ND].nq, ce[ND-1].y[31]);
    q[2] = hva_pkg::signed_quot(d2w[2][ND].nq, ce[ND-1].z[31]);
    if (ce[ND-1].kind == hva_pkg::KIND_NORM) begin
      if (d2w[0][ND].d == 32'd0) begin
        fin_next.x  = '0;
        fin_next.y  = '0;
        fin_next.z  = '0;
        fin_next.st = hva_pkg::ST_ZERO_LEN;
      end else begin
        for (int i = 0; i < 3; i++) begin
          anysat = anysat | q[i].ovf;
        end
        fin_next.x = q[0].val;
        fin_next.y = q[1].val;
        fin_next.z = q[2].val;
      end
    end
    fin_next.sat = anysat;
  end

  // output register; saturation outranks every other status
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ve[ND-1];
    end
  end

  always_ff @(posedge clk) begin
    res_x  <= fin_next.x;
    res_y  <= fin_next.y;
    res_z  <= fin_next.z;
    res_w  <= fin_next.w;
    status <= fin_next.sat ? hva_pkg::ST_SAT : fin_next.st;
  end

endmodule
`default_nettype wire

### hdl/hva_checker.sv
// port-level checks for the homogeneous vector alu, bound to the top level
`default_nettype none
`include "homogeneous_vector_alu_unit_assert.svh"
module hva_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               busy,
  input wire logic               done,
  input wire logic signed [31:0] res_x,
  input wire logic signed [31:0] res_y,
  input wire logic signed [31:0] res_z,
  input wire logic signed [31:0] res_w,
  input wire logic [1:0]         status
);

  // a zero length always comes with cleared x, y, z
  `HVA_ASSERT_SAME(a_zero_len_clears, done && status == hva_pkg::ST_ZERO_LEN, res_x == 32'sd0 && res_y == 32'sd0 && res_z == 32'sd0)

  // zero length comes from normalize, whose w is 0 or one
  `HVA_ASSERT_SAME(a_zero_len_w, done && status == hva_pkg::ST_ZERO_LEN, res_w == 32'sd0 || res_w == hva_pkg::Q_ONE)

  // bad w is only flagged when w really is neither 0 nor one
  `HVA_ASSERT_SAME(a_bad_w_real, done && status == hva_pkg::ST_BAD_W, res_w != 32'sd0 && res_w != hva_pkg::Q_ONE)

  // a transfer is refused only while in reset
  `HVA_ASSERT_NEXT(a_busy_reset, !rst, !busy)

endmodule

bind homogeneous_vector_alu_unit hva_checker u_hva_checker (.*);
`default_nettype wire
